/* hdl/mid_range_mcu_instruction_execute_macros.svh */
// Assertion macros for the module that checks its own logic.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MID_RANGE_MCU_INSTRUCTION_EXECUTE_MACROS_SVH
`define MID_RANGE_MCU_INSTRUCTION_EXECUTE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mre_pkg.sv */
package mre_pkg;

  localparam int INSN_W          = 14;
  localparam int FILE_DEPTH      = 128;
  localparam int ADDR_W          = $clog2(FILE_DEPTH);
  localparam int PC_W            = 13;
  localparam int PC_BITS_DEFAULT = 13;
  localparam int FLAGS_W         = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] STATUS_ADDR = ADDR_W'(3);

  // Status bit positions.
  localparam int FLAG_C  = 0;
  localparam int FLAG_DC = 1;
  localparam int FLAG_Z  = 2;

  // Instruction groups, bits 13:12.
  localparam logic [1:0] GRP_BYTE = 2'd0;
  localparam logic [1:0] GRP_BIT  = 2'd1;
  localparam logic [1:0] GRP_LIT  = 2'd3;

  // Byte-oriented opcodes, bits 11:8.
  localparam logic [3:0] SUB_MOVWF  = 4'h0;
  localparam logic [3:0] SUB_CLR    = 4'h1;
  localparam logic [3:0] SUB_SUBWF  = 4'h2;
  localparam logic [3:0] SUB_DECF   = 4'h3;
  localparam logic [3:0] SUB_IORWF  = 4'h4;
  localparam logic [3:0] SUB_ANDWF  = 4'h5;
  localparam logic [3:0] SUB_XORWF  = 4'h6;
  localparam logic [3:0] SUB_ADDWF  = 4'h7;
  localparam logic [3:0] SUB_MOVF   = 4'h8;
  localparam logic [3:0] SUB_COMF   = 4'h9;
  localparam logic [3:0] SUB_INCF   = 4'hA;
  localparam logic [3:0] SUB_DECFSZ = 4'hB;
  localparam logic [3:0] SUB_RRF    = 4'hC;
  localparam logic [3:0] SUB_RLF    = 4'hD;
  localparam logic [3:0] SUB_SWAPF  = 4'hE;
  localparam logic [3:0] SUB_INCFSZ = 4'hF;

  // Bit-oriented opcodes, bits 11:10.
  localparam logic [1:0] BOP_BCF   = 2'd0;
  localparam logic [1:0] BOP_BSF   = 2'd1;
  localparam logic [1:0] BOP_BTFSC = 2'd2;
  localparam logic [1:0] BOP_BTFSS = 2'd3;

  // Literal opcodes: ADDLW on bits 11:9, ANDLW on bits 11:8.
  localparam logic [2:0] LIT_ADDLW = 3'b111;
  localparam logic [3:0] LIT_ANDLW = 4'h9;

  typedef enum logic [4:0] {
    OP_NOP, OP_UNSUP, OP_MOVWF, OP_CLR, OP_DECF, OP_IORWF, OP_ANDWF, OP_XORWF,
    OP_ADDWF, OP_MOVF, OP_COMF, OP_INCF, OP_DECFSZ, OP_RRF, OP_RLF, OP_SWAPF,
    OP_INCFSZ, OP_BCF, OP_BSF, OP_BTFSC, OP_BTFSS, OP_ADDLW, OP_ANDLW
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              dest_f;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
    logic [7:0]        lit;
  } dec_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

/* hdl/mre_intf.sv */
interface mre_insn_if;
  logic                        valid;
  logic                        ready;
  logic [mre_pkg::INSN_W-1:0]  instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface mre_res_if;
  logic                         valid;
  logic                         ready;
  logic [mre_pkg::PC_W-1:0]     next_pc;
  logic [7:0]                   w_value;
  logic [mre_pkg::FLAGS_W-1:0]  flags;
  logic                         skipped;
  logic                         file_written;
  logic [mre_pkg::ADDR_W-1:0]   write_address;
  logic [7:0]                   write_data;
  logic                         unsupported;

  modport source (output valid, output next_pc, output w_value, output flags,
                  output skipped, output file_written, output write_address,
                  output write_data, output unsupported, input ready);
  modport sink (input valid, input next_pc, input w_value, input flags,
                input skipped, input file_written, input write_address,
                input write_data, input unsupported, output ready);
endinterface

/* hdl/mre_front.sv */
module mre_front (
  mre_insn_if.sink            instr,
  input  mre_pkg::q_status_t  q_stat,
  output logic                push,
  output mre_pkg::dec_t       push_item
);
  import mre_pkg::*;

  logic [INSN_W-1:0] ins;

  assign ins         = instr.instruction;
  assign instr.ready = !q_stat.full;
  assign push        = instr.valid && !q_stat.full;

  always_comb begin
    push_item.op      = OP_UNSUP;
    push_item.dest_f  = ins[7];
    push_item.addr    = ins[ADDR_W-1:0];
    push_item.bit_sel = ins[9:7];
    push_item.lit     = ins[7:0];
    case (ins[13:12])
      GRP_BYTE: begin
        case (ins[11:8])
          SUB_MOVWF: begin
            if (ins[7]) begin
              push_item.op = OP_MOVWF;
            end else if (ins[4:0] != 5'd0) begin
              push_item.op = OP_UNSUP;
            end else begin
              push_item.op = OP_NOP;
            end
          end
          SUB_CLR:    push_item.op = OP_CLR;
          SUB_SUBWF:  push_item.op = OP_UNSUP;
          SUB_DECF:   push_item.op = OP_DECF;
          SUB_IORWF:  push_item.op = OP_IORWF;
          SUB_ANDWF:  push_item.op = OP_ANDWF;
          SUB_XORWF:  push_item.op = OP_XORWF;
          SUB_ADDWF:  push_item.op = OP_ADDWF;
          SUB_MOVF:   push_item.op = OP_MOVF;
          SUB_COMF:   push_item.op = OP_COMF;
          SUB_INCF:   push_item.op = OP_INCF;
          SUB_DECFSZ: push_item.op = OP_DECFSZ;
          SUB_RRF:    push_item.op = OP_RRF;
          SUB_RLF:    push_item.op = OP_RLF;
          SUB_SWAPF:  push_item.op = OP_SWAPF;
          SUB_INCFSZ: push_item.op = OP_INCFSZ;
          default:    push_item.op = OP_UNSUP;
        endcase
      end
      GRP_BIT: begin
        case (ins[11:10])
          BOP_BCF:   push_item.op = OP_BCF;
          BOP_BSF:   push_item.op = OP_BSF;
          BOP_BTFSC: push_item.op = OP_BTFSC;
          BOP_BTFSS: push_item.op = OP_BTFSS;
          default:   push_item.op = OP_UNSUP;
        endcase
      end
      GRP_LIT: begin
        if (ins[11:9] == LIT_ADDLW) begin
          push_item.op = OP_ADDLW;
        end else if (ins[11:8] == LIT_ANDLW) begin
          push_item.op = OP_ANDLW;
        end else begin
          push_item.op = OP_UNSUP;
        end
      end
      default: push_item.op = OP_UNSUP;
    endcase
  end

endmodule

/* hdl/mre_queue.sv */
module mre_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mre_pkg::dec_t       push_item,
  input  logic                pop,
  output mre_pkg::dec_t       head,
  output mre_pkg::q_status_t  q_stat
);
  import mre_pkg::*;

  dec_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/mre_back.sv */
module mre_back #(
  parameter int PC_BITS = mre_pkg::PC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  mre_pkg::dec_t       head,
  input  mre_pkg::q_status_t  q_stat,
  output logic                pop,
  mre_res_if.source           result
);
  import mre_pkg::*;

  // Execute stage register and the registered file read that goes with it.
  logic              ex_valid;
  dec_t              ex_item;
  logic [7:0]        mem_rd;
  logic              vld_rd;
  logic              fwd_hit;
  logic [7:0]        fwd_data;

  // Architectural state.
  logic [7:0]         work_reg;
  logic [7:0]         status_reg;
  logic [PC_BITS-1:0] prog_counter;
  logic [7:0]         file_mem [FILE_DEPTH];
  logic [FILE_DEPTH-1:0] file_vld;

  logic               ex_fire;
  logic [7:0]         fv;
  logic [7:0]         addend;
  logic [8:0]         sum;
  logic [4:0]         nib;
  logic [7:0]         bmask;
  logic [7:0]         r;
  logic               has_r;
  logic               set_z;
  logic               unsup;
  logic               skip;
  logic               wrote;
  logic [7:0]         wdat;
  logic [7:0]         w_next;
  logic [7:0]         st_base;
  logic [7:0]         status_next;
  logic [7:0]         final_wdat;
  logic               c_upd, c_val, dc_upd, dc_val, z_upd, z_val;
  logic [PC_BITS-1:0] pc_next;

  assign ex_fire = ex_valid && (!result.valid || result.ready);
  assign pop     = !q_stat.empty && (!ex_valid || ex_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (pop) begin
      ex_valid <= 1'b1;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  // A write retiring on the same edge as this read is not seen by the
  // array read, so it is caught and forwarded.
  always_ff @(posedge clk) begin
    if (pop) begin
      ex_item  <= head;
      mem_rd   <= file_mem[head.addr];
      vld_rd   <= file_vld[head.addr];
      fwd_hit  <= ex_fire && wrote && (ex_item.addr == head.addr);
      fwd_data <= final_wdat;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire && wrote) begin
      file_mem[ex_item.addr] <= final_wdat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_vld <= '0;
    end else if (ex_fire && wrote) begin
      file_vld[ex_item.addr] <= 1'b1;
    end
  end

  always_comb begin
    if (ex_item.addr == STATUS_ADDR) begin
      fv = status_reg;
    end else if (fwd_hit) begin
      fv = fwd_data;
    end else if (vld_rd) begin
      fv = mem_rd;
    end else begin
      fv = 8'h00;
    end
  end

  always_comb begin
    addend = (ex_item.op == OP_ADDLW) ? ex_item.lit : fv;
    sum    = {1'b0, addend} + {1'b0, work_reg};
    nib    = {1'b0, addend[3:0]} + {1'b0, work_reg[3:0]};
    bmask  = 8'h01 << ex_item.bit_sel;
    r      = 8'h00;
    has_r  = 1'b0;
    set_z  = 1'b0;
    unsup  = 1'b0;
    skip   = 1'b0;
    wrote  = 1'b0;
    wdat   = 8'h00;
    w_next = work_reg;
    c_upd  = 1'b0;
    c_val  = 1'b0;
    dc_upd = 1'b0;
    dc_val = 1'b0;
    z_upd  = 1'b0;
    z_val  = 1'b0;
    case (ex_item.op)
      OP_NOP: begin
      end
      OP_UNSUP: unsup = 1'b1;
      OP_MOVWF: begin
        wrote = 1'b1;
        wdat  = work_reg;
      end
      OP_CLR: begin
        if (ex_item.dest_f) begin
          wrote = 1'b1;
          wdat  = 8'h00;
        end else begin
          w_next = 8'h00;
        end
        z_upd = 1'b1;
        z_val = 1'b1;
      end
      OP_DECF: begin
        r = fv - 8'd1; has_r = 1'b1; set_z = 1'b1;
      end
      OP_IORWF: begin
        r = fv | work_reg; has_r = 1'b1; set_z = 1'b1;
      end
      OP_ANDWF: begin
        r = fv & work_reg; has_r = 1'b1; set_z = 1'b1;
      end
      OP_XORWF: begin
        r = fv ^ work_reg; has_r = 1'b1; set_z = 1'b1;
      end
      OP_ADDWF: begin
        r = sum[7:0]; has_r = 1'b1; set_z = 1'b1;
        c_upd = 1'b1; c_val = sum[8];
        dc_upd = 1'b1; dc_val = nib[4];
      end
      OP_MOVF: begin
        r = fv; has_r = 1'b1; set_z = 1'b1;
      end
      OP_COMF: begin
        r = ~fv; has_r = 1'b1; set_z = 1'b1;
      end
      OP_INCF: begin
        r = fv + 8'd1; has_r = 1'b1; set_z = 1'b1;
      end
      OP_DECFSZ: begin
        r = fv - 8'd1; has_r = 1'b1; skip = (fv == 8'h01);
      end
      OP_INCFSZ: begin
        r = fv + 8'd1; has_r = 1'b1; skip = (fv == 8'hFF);
      end
      OP_RRF: begin
        r = {status_reg[FLAG_C], fv[7:1]}; has_r = 1'b1;
        c_upd = 1'b1; c_val = fv[0];
      end
      OP_RLF: begin
        r = {fv[6:0], status_reg[FLAG_C]}; has_r = 1'b1;
        c_upd = 1'b1; c_val = fv[7];
      end
      OP_SWAPF: begin
        r = {fv[3:0], fv[7:4]}; has_r = 1'b1;
      end
      OP_BCF: begin
        wrote = 1'b1;
        wdat  = fv & ~bmask;
      end
      OP_BSF: begin
        wrote = 1'b1;
        wdat  = fv | bmask;
      end
      OP_BTFSC: skip = ((fv & bmask) == 8'h00);
      OP_BTFSS: skip = ((fv & bmask) != 8'h00);
      OP_ADDLW: begin
        w_next = sum[7:0];
        c_upd = 1'b1; c_val = sum[8];
        dc_upd = 1'b1; dc_val = nib[4];
        z_upd = 1'b1; z_val = (sum[7:0] == 8'h00);
      end
      OP_ANDLW: begin
        w_next = work_reg & ex_item.lit;
        z_upd = 1'b1; z_val = ((work_reg & ex_item.lit) == 8'h00);
      end
      default: unsup = 1'b1;
    endcase

    if (has_r) begin
      if (ex_item.dest_f) begin
        wrote = 1'b1;
        wdat  = r;
      end else begin
        w_next = r;
      end
      if (set_z) begin
        z_upd = 1'b1;
        z_val = (r == 8'h00);
      end
    end

    // The result byte lands in the status register first; flag updates win.
    st_base     = (wrote && ex_item.addr == STATUS_ADDR) ? wdat : status_reg;
    status_next = st_base;
    if (c_upd) begin
      status_next[FLAG_C] = c_val;
    end
    if (dc_upd) begin
      status_next[FLAG_DC] = dc_val;
    end
    if (z_upd) begin
      status_next[FLAG_Z] = z_val;
    end
    final_wdat = (ex_item.addr == STATUS_ADDR) ? status_next : wdat;

    if (unsup) begin
      pc_next = prog_counter;
    end else begin
      pc_next = prog_counter + (skip ? PC_BITS'(2) : PC_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_reg     <= 8'h00;
      status_reg   <= 8'h00;
      prog_counter <= '0;
    end else if (ex_fire) begin
      work_reg     <= w_next;
      status_reg   <= status_next;
      prog_counter <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ex_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      result.next_pc       <= PC_W'(pc_next);
      result.w_value       <= w_next;
      result.flags         <= status_next[FLAGS_W-1:0];
      result.skipped       <= skip && !unsup;
      result.file_written  <= wrote;
      result.write_address <= wrote ? ex_item.addr : '0;
      result.write_data    <= wrote ? final_wdat : 8'h00;
      result.unsupported   <= unsup;
    end
  end

endmodule

/* hdl/mid_range_mcu_instruction_execute.sv */
// Mid-range microcontroller instruction executor. Each beat on instr carries
// one 14-bit instruction word in the standard mid-range encoding; each beat on
// result reports the program counter, W and the C/DC/Z flags after that
// instruction, whether the next instruction is skipped, the file register
// write it made and whether the opcode is unsupported (unsupported opcodes,
// SUBWF among them, change no state). The block sustains one instruction per
// clock cycle unless result stalls: a decode front end feeds a two-entry
// queue, and the execute back end reads the 128-byte file store through a
// registered read port, forwarding a write that retires on the same edge, so
// dependent instructions still issue back to back. Beats pass the queue, the
// execute stage register and the output register; while a result waits, the
// input takes beats until the queue is full. The file store is cleared at
// reset through per-entry valid bits, so no clearing pass is needed and the
// block is ready in the first cycle after reset.
`include "mid_range_mcu_instruction_execute_macros.svh"

module mid_range_mcu_instruction_execute #(
  parameter int PC_BITS = mre_pkg::PC_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  mre_insn_if.sink   instr,
  mre_res_if.source  result
);
  import mre_pkg::*;

  logic      push;
  dec_t      push_item;
  logic      pop;
  dec_t      head;
  q_status_t q_stat;

  // Front end: handshake and instruction classification.
  mre_front u_front (
    .instr     (instr),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Decoded instructions wait here so that either side can stall alone.
  mre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back end: file read, ALU, state update and the output register.
  mre_back #(
    .PC_BITS (PC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .result (result)
  );

  // An accepted beat is always held in the queue on the following cycle.
  `MRE_ASSERT_NEXT(a_accept_queued, instr.valid && instr.ready, !q_stat.empty, "accepted beat lost")
  // The queue never holds more entries than it has slots.
  `MRE_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overrun")
  // An unsupported opcode neither skips nor writes the file store.
  `MRE_ASSERT_NOW(a_unsup_quiet, result.valid && result.unsupported, !result.skipped && !result.file_written, "unsupported op had an effect")
  // Write address and data read as zero when no file register was written.
  `MRE_ASSERT_NOW(a_no_write_zero, result.valid && !result.file_written, result.write_address == '0 && result.write_data == 8'h00, "stale write fields")

endmodule
